>>> src/gael_pkg.sv
// Package with the types, constants and register codes of the gas alarm edge logger.
`default_nettype none
package gael_pkg;

	localparam int CH_W     = 3;
	localparam int CONC_W   = 8;
	localparam int TIME_W   = 48;
	localparam int SLOT_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int DEF_NUM_CHANNELS = 6;
	localparam int DEF_LOG_DEPTH    = 1024;

	localparam logic [CONC_W-1:0] FULL_SCALE = CONC_W'(100);

	localparam logic [CH_W-1:0]   RST_ACTIVE_CHANNELS    = CH_W'(6);
	localparam logic [CONC_W-1:0] RST_PREALARM_THRESHOLD = CONC_W'(25);
	localparam logic [CONC_W-1:0] RST_ALARM_THRESHOLD    = CONC_W'(50);

	localparam logic KIND_PRE   = 1'b0;
	localparam logic KIND_ALARM = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_CHANNELS    = 2'd0,
		CFG_PREALARM_THRESHOLD = 2'd1,
		CFG_ALARM_THRESHOLD    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic [CONC_W-1:0] concentration;
		logic [TIME_W-1:0] time_stamp;
	} in_item_t;

	typedef struct packed {
		logic               log_write;
		logic [SLOT_W-1:0]  log_slot;
		logic               log_kind;
		logic [CH_W-1:0]    log_channel;
		logic [TIME_W-1:0]  log_time;
		logic               relay_on;
		logic               prealarm_active;
		logic               alarm_active;
		logic [COUNT_W-1:0] slot_count;
		logic [COUNT_W-1:0] total_count;
		logic               log_wrapped;
	} out_item_t;

endpackage
`default_nettype wire

>>> src/gas_alarm_edge_logger.sv
// Gas alarm edge logger: per-channel alarm levels, relay latches and event log writes.
// An accepted reading goes to the input register and its result to the result register.
// Throughput: one reading per cycle while out_ready is not held low; the per-channel
// read-modify-write of the level, pending and relay latches and the slot and total
// counters all fit in the single compute stage between the input and result registers.
// Reset clears every level, pending latch, relay, counter and the wrap flag at once and
// loads the configuration registers with their defaults; no clearing pass is needed.
`default_nettype none
module gas_alarm_edge_logger
	import gael_pkg::*;
#(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	parameter int LOG_DEPTH    = DEF_LOG_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(LOG_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LOG_DEPTH);

	logic [CH_W-1:0]   active_q;
	logic [CONC_W-1:0] pre_th_q;
	logic [CONC_W-1:0] alm_th_q;

	logic [NUM_CHANNELS-1:0] pl_q, al_q, pp_q, pa_q, rl_q;
	logic [CNT_W-1:0]        slot_q, total_q;
	logic                    wrap_q;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;

	logic adv, fire;

	logic [NUM_CHANNELS-1:0] sel;
	logic ch_ok, clr;
	logic pl, al, pp, pa, rl;
	logic np, na, pp_n, pa_n, rl_n, wr;
	logic wrap_now;
	logic [CNT_W-1:0] slot_eff, slot_n, total_n;
	logic [CNT_W+COUNT_W-1:0] slot_eff_ext, slot_n_ext, total_n_ext;
	out_item_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= RST_ACTIVE_CHANNELS;
			pre_th_q <= RST_PREALARM_THRESHOLD;
			alm_th_q <= RST_ALARM_THRESHOLD;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ACTIVE_CHANNELS:    active_q <= cfg_data[CH_W-1:0];
				CFG_PREALARM_THRESHOLD: pre_th_q <= cfg_data[CONC_W-1:0];
				CFG_ALARM_THRESHOLD:    alm_th_q <= cfg_data[CONC_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_CHANNELS; j++) begin
			sel[j] = (32'(item_s1.channel) == 32'(j + 1));
		end
	end

	assign ch_ok = |sel;
	assign pl = |(pl_q & sel);
	assign al = |(al_q & sel);
	assign pp = |(pp_q & sel);
	assign pa = |(pa_q & sel);
	assign rl = |(rl_q & sel);
	assign clr = (item_s1.channel > active_q) || (item_s1.concentration <= pre_th_q);

	always_comb begin
		np = pl;
		na = al;
		if (item_s1.concentration <= alm_th_q) begin
			np = 1'b1;
			na = 1'b0;
		end else if (item_s1.concentration <= FULL_SCALE) begin
			na = 1'b1;
		end
		if (clr) begin
			np = 1'b0;
			na = 1'b0;
		end
	end

	assign pa_n = pa || (!clr && na && !al);
	assign pp_n = pp || (!clr && np && !pl);
	assign rl_n = !clr && (rl || (na && !al) || (np && !pl));
	assign wr   = ch_ok && !clr && (pp_n || pa_n);

	assign wrap_now = (slot_q == DEPTH_C);
	assign slot_eff = wrap_now ? '0 : slot_q;
	assign slot_n   = wr ? slot_eff + CNT_W'(1) : slot_q;
	assign total_n  = (wr && total_q != DEPTH_C) ? total_q + CNT_W'(1) : total_q;

	assign slot_eff_ext = {{COUNT_W{1'b0}}, slot_eff};
	assign slot_n_ext   = {{COUNT_W{1'b0}}, slot_n};
	assign total_n_ext  = {{COUNT_W{1'b0}}, total_n};

	always_comb begin
		res                 = '0;
		res.log_write       = wr;
		res.log_slot        = wr ? slot_eff_ext[SLOT_W-1:0] : '0;
		res.log_kind        = (wr && !pp_n) ? KIND_ALARM : KIND_PRE;
		res.log_channel     = wr ? item_s1.channel : '0;
		res.log_time        = wr ? item_s1.time_stamp : '0;
		res.relay_on        = ch_ok && rl_n;
		res.prealarm_active = ch_ok && np;
		res.alarm_active    = ch_ok && na;
		res.slot_count      = slot_n_ext[COUNT_W-1:0];
		res.total_count     = total_n_ext[COUNT_W-1:0];
		res.log_wrapped     = wrap_q || (wr && wrap_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q    <= '0;
			al_q    <= '0;
			pp_q    <= '0;
			pa_q    <= '0;
			rl_q    <= '0;
			slot_q  <= '0;
			total_q <= '0;
			wrap_q  <= 1'b0;
		end else if (fire) begin
			for (int j = 0; j < NUM_CHANNELS; j++) begin
				if (sel[j]) begin
					pl_q[j] <= np;
					al_q[j] <= na;
					rl_q[j] <= rl_n;
					pp_q[j] <= pp_n && !(wr && pp_n);
					pa_q[j] <= pa_n && !(wr && !pp_n);
				end
			end
			slot_q  <= slot_n;
			total_q <= total_n;
			if (wr && wrap_now) begin
				wrap_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= DEPTH_C)
		else $error("Event total exceeds the log depth.");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= DEPTH_C)
		else $error("Slot counter exceeds the log depth.");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_q |=> wrap_q)
		else $error("Wrap flag dropped after being set.");

	a_level_relay: assert property (@(posedge clk) disable iff (!arst_n)
		((pl_q | al_q) & ~rl_q) == '0)
		else $error("A raised level has no relay latched.");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.log_write) |->
		(res_s2.log_slot == '0 && res_s2.log_channel == '0 && res_s2.log_time == '0))
		else $error("Log fields not cleared in a transaction without a write.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(res_s2)))
		else $error("Result register changed while stalled.");

endmodule
`default_nettype wire
